@@ design/byte_stuffed_frame_decoder_top_defines.svh @@
// Assertion macros shared by the byte-stuffed frame decoder modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef BYTE_STUFFED_FRAME_DECODER_TOP_DEFINES_SVH
`define BYTE_STUFFED_FRAME_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bsfd_pkg.sv @@
// Package for the byte-stuffed frame decoder: line codes, status codes
// and the result record. No dependencies.
package bsfd_pkg;

  localparam logic [7:0] DELIM_BYTE      = 8'h7E;
  localparam logic [7:0] ESC_BYTE        = 8'h7D;
  localparam logic [7:0] ESC_XOR         = 8'h20;
  localparam logic [7:0] MAX_PAYLOAD_RST = 8'd255;
  localparam int         CountW          = 9;

  typedef enum logic [2:0] {
    STAT_NONE     = 3'd0,
    STAT_OK       = 3'd1,
    STAT_CSUM_ERR = 3'd2,
    STAT_ESC_ERR  = 3'd3,
    STAT_OVERFLOW = 3'd4
  } status_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data;
    status_t    status;
    logic [7:0] frame_len;
  } res_t;

endpackage

@@ design/bsfd_core.sv @@
// Frame state registers and the per-byte unstuffing, checksum and status logic.
// Depends on bsfd_pkg and byte_stuffed_frame_decoder_top_defines.svh.
`include "byte_stuffed_frame_decoder_top_defines.svh"

module bsfd_core
  import bsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] max_payload_i,
  output res_t       res_o
);

  logic              receiving_r, receiving_nxt;
  logic              escaping_r, escaping_nxt;
  logic              prev_delim_r, prev_delim_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        held_r, held_nxt;

  logic              is_delim;
  logic              is_esc;
  logic              store;
  logic [7:0]        store_val;
  logic [7:0]        sum_diff;
  logic [CountW-1:0] limit;
  logic              drop;

  assign is_delim = (byte_i == DELIM_BYTE);
  assign is_esc   = (byte_i == ESC_BYTE);
  assign sum_diff = sum_r - held_r;
  assign limit    = {1'b0, max_payload_i} + CountW'(1);

  always_comb begin
    receiving_nxt  = receiving_r;
    escaping_nxt   = escaping_r;
    prev_delim_nxt = is_delim;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    held_nxt       = held_r;
    store          = 1'b0;
    store_val      = byte_i;
    drop           = 1'b0;
    res_o          = '0;

    if (receiving_r) begin
      if (is_delim) begin
        drop = 1'b1;
        if (escaping_r) begin
          res_o.status = STAT_ESC_ERR;
        end else if (count_r != '0 && sum_diff == held_r) begin
          res_o.status    = STAT_OK;
          res_o.frame_len = 8'(count_r - CountW'(1));
          // A good frame consumes its closing delimiter.
          prev_delim_nxt  = 1'b0;
        end else begin
          res_o.status = STAT_CSUM_ERR;
        end
      end else if (count_r >= limit) begin
        res_o.status = STAT_OVERFLOW;
        drop         = 1'b1;
      end else if (escaping_r) begin
        escaping_nxt = 1'b0;
        store        = 1'b1;
        store_val    = byte_i ^ ESC_XOR;
      end else if (is_esc) begin
        escaping_nxt = 1'b1;
      end else begin
        store = 1'b1;
      end
    end else if (prev_delim_r && !is_delim) begin
      receiving_nxt = 1'b1;
      if (is_esc) begin
        escaping_nxt = 1'b1;
      end else begin
        store = 1'b1;
      end
    end

    // The held byte goes out only once a newer byte replaces it.
    if (store) begin
      if (count_r != '0) begin
        res_o.data_valid = 1'b1;
        res_o.data       = held_r;
      end
      held_nxt  = store_val;
      sum_nxt   = sum_r + store_val;
      count_nxt = count_r + CountW'(1);
    end

    if (drop) begin
      receiving_nxt = 1'b0;
      escaping_nxt  = 1'b0;
      count_nxt     = '0;
      sum_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r  <= 1'b0;
      escaping_r   <= 1'b0;
      prev_delim_r <= 1'b0;
      count_r      <= '0;
      sum_r        <= '0;
    end else if (step_i) begin
      receiving_r  <= receiving_nxt;
      escaping_r   <= escaping_nxt;
      prev_delim_r <= prev_delim_nxt;
      count_r      <= count_nxt;
      sum_r        <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i) begin
      held_r <= held_nxt;
    end
  end

  `BSFD_ASSERT_SAME(a_esc_in_frame, escaping_r, receiving_r, "escape pending outside a frame")
  `BSFD_ASSERT_SAME(a_count_in_frame, count_r != '0, receiving_r, "stored bytes outside a frame")
  `BSFD_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CountW'(256), "stored count past its bound")

endmodule

@@ design/byte_stuffed_frame_decoder_top.sv @@
// Byte-stuffed frame decoder top level: input register, decode core, result register.
// Depends on bsfd_pkg, bsfd_core and byte_stuffed_frame_decoder_top_defines.svh.
// The input register loads on an input transfer, the result register loads from the core
// once it frees up, and the result then transfers out; one result per input byte.
// Throughput: one byte per cycle while out_stall does not hold the result register.
// Reset (rst_n low, synchronous) empties both registers, clears frame state, max_payload 255.
`include "byte_stuffed_frame_decoder_top_defines.svh"

module byte_stuffed_frame_decoder_top
  import bsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_result_valid,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic [2:0] out_status,
  output logic [7:0] out_frame_len,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_max_payload
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_vld_r;
  res_t       out_res_r;
  res_t       core_res;
  logic [7:0] max_payload_r;
  logic       adv;
  logic       in_xfer;
  logic       step;

  // The result register frees up whenever it is empty or its transfer completes.
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_xfer  = in_valid && !in_stall;
  assign step     = s1_valid_r && adv;

  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_vld_r     <= 1'b0;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (adv) begin
        out_vld_r <= s1_valid_r;
      end
      if (cfg_valid && cfg_ready) begin
        max_payload_r <= cfg_max_payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_byte;
    end
    if (step) begin
      out_res_r <= core_res;
    end
  end

  bsfd_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_i        (step),
    .byte_i        (s1_byte_r),
    .max_payload_i (max_payload_r),
    .res_o         (core_res)
  );

  assign out_result_valid = out_vld_r;
  assign out_valid        = out_res_r.data_valid;
  assign out_byte         = out_res_r.data;
  assign out_status       = out_res_r.status;
  assign out_frame_len    = out_res_r.frame_len;

  `BSFD_ASSERT_NEXT(a_step_fills_out, step, out_vld_r, "result register not loaded")
  `BSFD_ASSERT_SAME(a_data_nostat, out_vld_r && out_valid, out_status == STAT_NONE, "stray status")
  `BSFD_ASSERT_SAME(a_ok_no_data, out_vld_r && out_status == STAT_OK, !out_valid, "stray byte")

endmodule
